FILE: rtl/ote_pkg.sv
// shared types and constants of the object tree engine
`default_nettype none
package ote_pkg;
	localparam int LINK_W = 10;
	localparam int ATTR_W = 48;
	localparam int REQ_W  = 4;
	localparam int ERR_W  = 3;

	localparam logic [REQ_W-1:0] REQ_INSERT  = 4'd0;
	localparam logic [REQ_W-1:0] REQ_REMOVE  = 4'd1;
	localparam logic [REQ_W-1:0] REQ_PARENT  = 4'd2;
	localparam logic [REQ_W-1:0] REQ_CHILD   = 4'd3;
	localparam logic [REQ_W-1:0] REQ_SIBLING = 4'd4;
	localparam logic [REQ_W-1:0] REQ_INSIDE  = 4'd5;
	localparam logic [REQ_W-1:0] REQ_SETATTR = 4'd6;
	localparam logic [REQ_W-1:0] REQ_CLRATTR = 4'd7;
	localparam logic [REQ_W-1:0] REQ_TSTATTR = 4'd8;
	localparam logic [REQ_W-1:0] REQ_LOAD    = 4'd9;

	localparam logic [ERR_W-1:0] ERR_OK      = 3'd0;
	localparam logic [ERR_W-1:0] ERR_OBJECT  = 3'd1;
	localparam logic [ERR_W-1:0] ERR_SECOND  = 3'd2;
	localparam logic [ERR_W-1:0] ERR_ATTR    = 3'd3;
	localparam logic [ERR_W-1:0] ERR_ZERO    = 3'd4;
	localparam logic [ERR_W-1:0] ERR_CHAIN   = 3'd5;

	localparam logic [1:0] TBL_PARENT  = 2'd0;
	localparam logic [1:0] TBL_SIBLING = 2'd1;
	localparam logic [1:0] TBL_CHILD   = 2'd2;
	localparam logic [1:0] TBL_ATTR    = 2'd3;

	// one memory access from the sequencer
	typedef struct packed {
		logic                rd;
		logic                wr;
		logic [1:0]          tbl;
		logic [LINK_W-1:0]   addr;
		logic [ATTR_W-1:0]   wdata;
	} mem_req_t;

	typedef struct packed {
		logic [REQ_W-1:0]  req_type;
		logic [LINK_W-1:0] object;
		logic [LINK_W-1:0] target;
		logic [LINK_W-1:0] load_parent;
		logic [LINK_W-1:0] load_sibling;
		logic [LINK_W-1:0] load_child;
		logic [ATTR_W-1:0] load_attrs;
	} item_t;
endpackage
`default_nettype wire

FILE: rtl/ote_tables.sv
// link and attribute memories, one access per cycle, registered read
`default_nettype none
module ote_tables import ote_pkg::*; #(
	parameter int SLOTS = 1024
) (
	input  wire logic              clk,
	input  mem_req_t               req,
	output logic [ATTR_W-1:0]      rdata
);
	localparam int AW = $clog2(SLOTS);
	logic [LINK_W-1:0] par_mem [SLOTS];
	logic [LINK_W-1:0] sib_mem [SLOTS];
	logic [LINK_W-1:0] chd_mem [SLOTS];
	logic [ATTR_W-1:0] att_mem [SLOTS];
	logic [AW-1:0] a;

	assign a = AW'(req.addr);

	always_ff @(posedge clk) begin
		if (req.wr) begin
			unique case (req.tbl)
				TBL_PARENT:  par_mem[a] <= req.wdata[LINK_W-1:0];
				TBL_SIBLING: sib_mem[a] <= req.wdata[LINK_W-1:0];
				TBL_CHILD:   chd_mem[a] <= req.wdata[LINK_W-1:0];
				default:     att_mem[a] <= req.wdata;
			endcase
		end
		if (req.rd) begin
			unique case (req.tbl)
				TBL_PARENT:  rdata <= ATTR_W'(par_mem[a]);
				TBL_SIBLING: rdata <= ATTR_W'(sib_mem[a]);
				TBL_CHILD:   rdata <= ATTR_W'(chd_mem[a]);
				default:     rdata <= att_mem[a];
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: rtl/ote_seq.sv
// request sequencer: checks, table walks and result register
`default_nettype none
module ote_seq import ote_pkg::*; #(
	parameter int SLOTS = 1024
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [3:0]        story_version,
	input  wire logic [LINK_W-1:0] highest_object,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  item_t                  item,
	output mem_req_t               mreq,
	input  wire logic [ATTR_W-1:0] rdata,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [LINK_W-1:0]      out_value,
	output logic                   out_branch,
	output logic [ERR_W-1:0]       out_error
);
	localparam int SW = $clog2(SLOTS + 1);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_CHECK  = 4'd1;
	localparam logic [3:0] ST_RDPAR  = 4'd2;  // detach: parent of object
	localparam logic [3:0] ST_RDSIB  = 4'd3;  // detach: sibling of object
	localparam logic [3:0] ST_RDCHD  = 4'd4;  // detach: first child of parent
	localparam logic [3:0] ST_WALK   = 4'd5;
	localparam logic [3:0] ST_UNL1   = 4'd6;
	localparam logic [3:0] ST_UNL2   = 4'd7;
	localparam logic [3:0] ST_INS0   = 4'd8;
	localparam logic [3:0] ST_INS1   = 4'd9;
	localparam logic [3:0] ST_RDONE  = 4'd10; // single read, then finish
	localparam logic [3:0] ST_ATTRW  = 4'd11;
	localparam logic [3:0] ST_LOAD   = 4'd12;
	localparam logic [3:0] ST_DONE   = 4'd13;
	localparam logic [3:0] ST_WAIT   = 4'd14; // wait for the registered table read

	logic [3:0]        state_q, next_q;
	item_t             it_q;
	logic [LINK_W-1:0] up_q, older_q, walk_q, prev_q;
	logic [SW-1:0]     steps_q;
	logic [1:0]        lcnt_q;
	logic              walked_q;
	logic [LINK_W-1:0] value_q;
	logic              branch_q;
	logic [ERR_W-1:0]  err_q;
	logic              ovalid_q;

	logic byte_links;
	logic [5:0] max_attr;
	logic [ATTR_W-1:0] bitmask;
	logic [LINK_W-1:0] rlink;

	function automatic logic obj_ok(input logic [LINK_W-1:0] n, input logic [LINK_W-1:0] hi);
		return n != '0 && n <= hi;
	endfunction

	assign byte_links = story_version < 4'd4;
	assign max_attr   = byte_links ? 6'd31 : 6'd47;
	assign bitmask    = ATTR_W'(1) << (6'd47 - it_q.target[5:0]);
	assign rlink      = rdata[LINK_W-1:0];

	function automatic logic [LINK_W-1:0] fit(input logic [LINK_W-1:0] v, input logic b);
		return b ? {2'b00, v[7:0]} : v;
	endfunction

	assign in_ready   = state_q == ST_IDLE && !ovalid_q;
	assign out_valid  = ovalid_q;
	assign out_value  = value_q;
	assign out_branch = branch_q;
	assign out_error  = err_q;

	always_comb begin
		mreq = '0;
		unique case (state_q)
			ST_CHECK: begin
				mreq.rd = 1'b1;
				mreq.addr = it_q.object;
				priority if (it_q.req_type == REQ_CHILD) mreq.tbl = TBL_CHILD;
				else if (it_q.req_type == REQ_SIBLING) mreq.tbl = TBL_SIBLING;
				else if (it_q.req_type == REQ_SETATTR || it_q.req_type == REQ_CLRATTR
					|| it_q.req_type == REQ_TSTATTR) mreq.tbl = TBL_ATTR;
				else mreq.tbl = TBL_PARENT;
			end
			ST_RDPAR: begin
				mreq.rd = 1'b1; mreq.tbl = TBL_SIBLING; mreq.addr = it_q.object;
			end
			ST_RDSIB: begin
				mreq.rd = 1'b1; mreq.tbl = TBL_CHILD; mreq.addr = up_q;
			end
			ST_WALK: begin
				mreq.rd = 1'b1; mreq.tbl = TBL_SIBLING; mreq.addr = walk_q;
			end
			ST_UNL1: begin
				mreq.wr = 1'b1;
				mreq.tbl = walked_q ? TBL_SIBLING : TBL_CHILD;
				mreq.addr = walked_q ? prev_q : up_q;
				mreq.wdata = ATTR_W'(fit(older_q, byte_links));
			end
			ST_UNL2: begin
				mreq.wr = 1'b1;
				mreq.tbl = lcnt_q[0] ? TBL_SIBLING : TBL_PARENT;
				mreq.addr = it_q.object;
			end
			ST_INS0: begin
				mreq.rd = 1'b1; mreq.tbl = TBL_CHILD; mreq.addr = it_q.target;
			end
			ST_INS1: begin
				mreq.wr = 1'b1;
				unique case (lcnt_q)
					2'd0: begin mreq.tbl = TBL_PARENT; mreq.addr = it_q.object;
						mreq.wdata = ATTR_W'(fit(it_q.target, byte_links)); end
					2'd1: begin mreq.tbl = TBL_CHILD; mreq.addr = it_q.target;
						mreq.wdata = ATTR_W'(fit(it_q.object, byte_links)); end
					default: begin mreq.tbl = TBL_SIBLING; mreq.addr = it_q.object;
						mreq.wdata = ATTR_W'(fit(walk_q, byte_links)); end
				endcase
			end
			ST_ATTRW: begin
				mreq.wr = 1'b1; mreq.tbl = TBL_ATTR; mreq.addr = it_q.object;
				mreq.wdata = (it_q.req_type == REQ_SETATTR) ? (rdata | bitmask)
					: (rdata & ~bitmask);
			end
			ST_LOAD: begin
				mreq.wr = 1'b1; mreq.addr = it_q.object; mreq.tbl = lcnt_q;
				unique case (lcnt_q)
					TBL_PARENT:  mreq.wdata = ATTR_W'(fit(it_q.load_parent, byte_links));
					TBL_SIBLING: mreq.wdata = ATTR_W'(fit(it_q.load_sibling, byte_links));
					TBL_CHILD:   mreq.wdata = ATTR_W'(fit(it_q.load_child, byte_links));
					default:     mreq.wdata = it_q.load_attrs;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			next_q   <= ST_IDLE;
			ovalid_q <= 1'b0;
			lcnt_q   <= '0;
			steps_q  <= '0;
			walked_q <= 1'b0;
		end else begin
			if (ovalid_q && out_ready) ovalid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (in_valid && in_ready) begin
					it_q     <= item;
					value_q  <= '0;
					branch_q <= 1'b0;
					err_q    <= ERR_OK;
					lcnt_q   <= '0;
					steps_q  <= '0;
					walked_q <= 1'b0;
					state_q  <= ST_CHECK;
				end
				ST_CHECK: begin
					// every read path goes through a wait state
					state_q <= ST_WAIT;
					unique case (it_q.req_type)
						REQ_INSERT, REQ_INSIDE: begin
							if (!obj_ok(it_q.object, highest_object)) begin
								err_q <= ERR_OBJECT; state_q <= ST_DONE;
							end else if (!obj_ok(it_q.target, highest_object)) begin
								err_q <= ERR_SECOND; state_q <= ST_DONE;
							end else next_q <= (it_q.req_type == REQ_INSIDE)
								? ST_RDONE : ST_RDPAR;
						end
						REQ_REMOVE: begin
							if (it_q.object == '0) begin
								err_q <= ERR_ZERO; state_q <= ST_DONE;
							end else if (it_q.object > highest_object) begin
								err_q <= ERR_OBJECT; state_q <= ST_DONE;
							end else next_q <= ST_RDPAR;
						end
						REQ_PARENT, REQ_CHILD, REQ_SIBLING: begin
							if (!obj_ok(it_q.object, highest_object)) begin
								err_q <= ERR_OBJECT; state_q <= ST_DONE;
							end else next_q <= ST_RDONE;
						end
						REQ_SETATTR, REQ_CLRATTR, REQ_TSTATTR: begin
							if (it_q.target > LINK_W'(max_attr)) begin
								err_q <= ERR_ATTR; state_q <= ST_DONE;
							end else if (!obj_ok(it_q.object, highest_object)) begin
								err_q <= ERR_OBJECT; state_q <= ST_DONE;
							end else next_q <= (it_q.req_type == REQ_TSTATTR)
								? ST_RDONE : ST_ATTRW;
						end
						REQ_LOAD: begin
							if (!obj_ok(it_q.object, highest_object)) begin
								err_q <= ERR_OBJECT; state_q <= ST_DONE;
							end else state_q <= ST_LOAD;
						end
						default: state_q <= ST_DONE;
					endcase
				end
				ST_WAIT: state_q <= next_q;
				ST_RDONE: begin
					unique case (it_q.req_type)
						REQ_INSIDE:  branch_q <= rlink == it_q.target;
						REQ_TSTATTR: branch_q <= (rdata & bitmask) != '0;
						REQ_PARENT:  value_q <= rlink;
						default: begin
							value_q <= rlink; branch_q <= rlink != '0;
						end
					endcase
					state_q <= ST_DONE;
				end
				ST_ATTRW: state_q <= ST_DONE;
				ST_RDPAR: begin
					up_q <= rlink;
					if (rlink == '0)
						state_q <= (it_q.req_type == REQ_INSERT) ? ST_INS0 : ST_DONE;
					else begin
						next_q <= ST_RDSIB; state_q <= ST_WAIT;
					end
				end
				ST_RDSIB: begin
					older_q <= rlink; next_q <= ST_RDCHD; state_q <= ST_WAIT;
				end
				ST_RDCHD: begin
					walk_q <= rlink;
					state_q <= (rlink == it_q.object) ? ST_UNL1 : ST_WALK;
					if (rlink != it_q.object) begin
						if (rlink == '0) begin
							err_q <= ERR_CHAIN; state_q <= ST_DONE;
						end
					end
				end
				ST_WALK: begin
					// read of sibling(walk) issued here; result taken in RDCHD path
					prev_q   <= walk_q;
					walked_q <= 1'b1;
					steps_q  <= steps_q + SW'(1);
					next_q   <= ST_RDCHD;
					state_q  <= ST_WAIT;
					if (steps_q >= SW'(SLOTS)) begin
						err_q <= ERR_CHAIN; state_q <= ST_DONE;
					end
				end
				ST_UNL1: begin lcnt_q <= '0; state_q <= ST_UNL2; end
				ST_UNL2: begin
					lcnt_q <= lcnt_q + 2'd1;
					if (lcnt_q[0]) begin
						lcnt_q <= '0;
						state_q <= (it_q.req_type == REQ_INSERT) ? ST_INS0 : ST_DONE;
					end
				end
				ST_INS0: begin next_q <= ST_INS1; state_q <= ST_WAIT; lcnt_q <= '0; end
				ST_INS1: begin
					if (lcnt_q == 2'd0) walk_q <= rlink;
					lcnt_q <= lcnt_q + 2'd1;
					if (lcnt_q == 2'd2) state_q <= ST_DONE;
				end
				ST_LOAD: begin
					lcnt_q <= lcnt_q + 2'd1;
					if (lcnt_q == 2'd3) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (err_q != ERR_OK) begin
						value_q <= '0; branch_q <= 1'b0;
					end
					ovalid_q <= 1'b1;
					state_q  <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: rtl/object_tree_engine_top.sv
// object tree engine: top level with register port and stream channels
//
// channel   dir  beat fields (low bit first)
// s_axis    in   req_type, object, target, load_parent, load_sibling, load_child, load_attrs
// m_axis    out  value, branch, error
// apb       cfg  story_version at 0x0, highest_object at 0x4
//
// one request at a time; the result beat shows once the request's checks and table
// accesses are done, remove and insert also walking the sibling chain, all through
// the single-port table memories. reset clears the control state and sets
// story_version to 3 and highest_object to 255; table contents stay undefined
// until loaded. a stalled result holds the block idle until the beat is taken.
`default_nettype none
module object_tree_engine_top import ote_pkg::*; #(
	parameter int OBJECT_SLOTS = 1024
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [2:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// req_type[3:0], object[13:4], target[23:14], load_parent[33:24],
	// load_sibling[43:34], load_child[53:44], load_attrs[101:54], pad to 104
	input  wire logic [103:0] s_axis_tdata,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// value[9:0], branch[10], error[13:11], pad to 16
	output logic [15:0]       m_axis_tdata
);
	logic [3:0]        version_q;
	logic [LINK_W-1:0] highest_q;
	item_t             item;
	mem_req_t          mreq;
	logic [ATTR_W-1:0] rdata;
	logic [LINK_W-1:0] value;
	logic              branch;
	logic [ERR_W-1:0]  error;

	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			version_q <= 4'd3;
			highest_q <= 10'd255;
		end else if (psel && penable && pwrite) begin
			if (paddr == 3'd0) version_q <= pwdata[3:0];
			else if (paddr == 3'd4) highest_q <= pwdata[LINK_W-1:0];
		end
	end
	always_comb begin
		prdata = '0;
		if (paddr == 3'd0) prdata = 32'(version_q);
		else if (paddr == 3'd4) prdata = 32'(highest_q);
	end

	assign item.req_type     = s_axis_tdata[3:0];
	assign item.object       = s_axis_tdata[13:4];
	assign item.target       = s_axis_tdata[23:14];
	assign item.load_parent  = s_axis_tdata[33:24];
	assign item.load_sibling = s_axis_tdata[43:34];
	assign item.load_child   = s_axis_tdata[53:44];
	assign item.load_attrs   = s_axis_tdata[101:54];

	ote_seq #(.SLOTS(OBJECT_SLOTS)) u_seq (
		.clk, .arst_n,
		.story_version(version_q), .highest_object(highest_q),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .item,
		.mreq, .rdata,
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_value(value), .out_branch(branch), .out_error(error)
	);

	ote_tables #(.SLOTS(OBJECT_SLOTS)) u_tables (.clk, .req(mreq), .rdata);

	assign m_axis_tdata = {2'b00, error, branch, value};
endmodule
`default_nettype wire

FILE: rtl/ote_checker.sv
// port-level checks of the object tree engine, bound to the top level
`default_nettype none
module ote_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [15:0] m_axis_tdata
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result beat dropped while stalled");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second request taken while busy");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("request taken with result pending");
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[13:11] != 3'd0 |-> m_axis_tdata[10:0] == 11'd0)
		else $error("error result carries data");
endmodule

bind object_tree_engine_top ote_checker u_chk (.*);
`default_nettype wire
